FILE: design/fr_pkg.sv
// Package for the fraction reducer: defaults, sequencer states and status codes.
`default_nettype none
package fr_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_GCD,
    FR_DIV_TOP,
    FR_DIV_BOT,
    FR_DONE
  } fr_state_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_NUM  = 2'd1,
    ST_DIV_ZERO  = 2'd2
  } fr_status_t;

endpackage
`default_nettype wire

FILE: design/fraction_reducer.sv
// Fraction reducer top level: binary GCD and two restoring divisions on one subtractor.
//
// Takes a signed numerator and denominator (in_top_value, in_bottom_value) and returns the
// magnitudes in lowest terms, the two input signs as given (the top sign cleared for a zero
// numerator), and a status code. One item is worked on at a time; in_ready is high only
// while the sequencer is idle. A zero numerator (checked first) or a zero denominator goes
// straight from idle to the done state with zero magnitudes. Otherwise the item is
// accepted, then a binary GCD runs at one step per cycle, then two restoring divisions of
// DATA_WIDTH steps each run, then the output register is loaded. One shared DATA_WIDTH+1
// bit subtractor serves both the GCD compare/subtract and every division step. Common
// factors of two are stripped from the working magnitudes during the GCD so the divisor is
// always the odd part of the GCD. The result sits in an output register, so the next item
// is accepted as soon as the result is loaded there.
`default_nettype none
module fraction_reducer
  import fr_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [DATA_WIDTH-1:0] in_top_value,
  input  wire logic signed [DATA_WIDTH-1:0] in_bottom_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [DATA_WIDTH-1:0]             out_top_magnitude,
  output logic [DATA_WIDTH-1:0]             out_bottom_magnitude,
  output logic                              out_top_negative,
  output logic                              out_bottom_negative,
  output logic [1:0]                        out_status
);

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  fr_state_t state_r, state_nxt;

  // GCD working pair, scaled magnitudes (later the quotients), division remainder
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [DATA_WIDTH-1:0] tn_r, tn_nxt;
  logic [DATA_WIDTH-1:0] bn_r, bn_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  tneg_r, tneg_nxt;
  logic                  bneg_r, bneg_nxt;
  fr_status_t            status_r, status_nxt;

  logic [DATA_WIDTH-1:0] out_top_r, out_bot_r;
  logic                  out_tneg_r, out_bneg_r;
  fr_status_t            out_status_r;
  logic                  out_valid_r;

  logic                  in_fire;
  logic                  out_free;
  logic [DATA_WIDTH-1:0] top_u, bot_u, top_mag, bot_mag;

  // Shared subtractor: compare/subtract for GCD, trial subtract for division
  logic [DATA_WIDTH:0]   op_a, op_b;
  logic [DATA_WIDTH+1:0] diff;
  logic                  borrow;
  logic [DATA_WIDTH-1:0] dvd;
  logic [DATA_WIDTH-1:0] q_step, rem_step;
  logic                  cnt_last;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Magnitude of the most negative value is 2^(DATA_WIDTH-1), which fits unsigned
  assign top_u   = in_top_value;
  assign bot_u   = in_bottom_value;
  assign top_mag = top_u[DATA_WIDTH-1] ? (~top_u + 1'b1) : top_u;
  assign bot_mag = bot_u[DATA_WIDTH-1] ? (~bot_u + 1'b1) : bot_u;

  assign dvd  = (state_r == FR_DIV_BOT) ? bn_r : tn_r;
  assign op_a = (state_r == FR_GCD) ? {1'b0, a_r} : {rem_r, dvd[DATA_WIDTH-1]};
  assign op_b = (state_r == FR_GCD) ? {1'b0, b_r} : {1'b0, a_r};
  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign borrow = diff[DATA_WIDTH+1];

  // One restoring-division step: shift the quotient bit in, keep or restore the remainder
  assign q_step   = {dvd[DATA_WIDTH-2:0], ~borrow};
  assign rem_step = borrow ? {rem_r[DATA_WIDTH-2:0], dvd[DATA_WIDTH-1]} : diff[DATA_WIDTH-1:0];
  assign cnt_last = (cnt_r == CNT_LAST);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: begin
        if (in_valid) begin
          if (top_mag == '0 || bot_mag == '0) begin
            state_nxt = FR_DONE;
          end else begin
            state_nxt = FR_GCD;
          end
        end
      end
      FR_GCD: begin
        if (a_r[0] && b_r[0] && diff == '0) begin
          state_nxt = FR_DIV_TOP;
        end
      end
      FR_DIV_TOP: begin
        if (cnt_last) begin
          state_nxt = FR_DIV_BOT;
        end
      end
      FR_DIV_BOT: begin
        if (cnt_last) begin
          state_nxt = FR_DONE;
        end
      end
      FR_DONE: begin
        if (out_free) begin
          state_nxt = FR_IDLE;
        end
      end
      default: begin
        state_nxt = FR_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready = (state_r == FR_IDLE);
  end

  // Datapath next values
  always_comb begin
    a_nxt      = a_r;
    b_nxt      = b_r;
    tn_nxt     = tn_r;
    bn_nxt     = bn_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    tneg_nxt   = tneg_r;
    bneg_nxt   = bneg_r;
    status_nxt = status_r;
    case (state_r)
      FR_IDLE: begin
        if (in_valid) begin
          // Latch the item; the zero numerator check wins over the zero denominator check
          a_nxt    = top_mag;
          b_nxt    = bot_mag;
          tn_nxt   = top_mag;
          bn_nxt   = bot_mag;
          tneg_nxt = top_u[DATA_WIDTH-1];
          bneg_nxt = bot_u[DATA_WIDTH-1];
          if (top_mag == '0) begin
            status_nxt = ST_ZERO_NUM;
            tneg_nxt   = 1'b0;
          end else if (bot_mag == '0) begin
            status_nxt = ST_DIV_ZERO;
          end else begin
            status_nxt = ST_OK;
          end
        end
      end
      FR_GCD: begin
        if (!a_r[0] && !b_r[0]) begin
          // Common factor of two: drop it from the pair and from both magnitudes
          a_nxt  = a_r >> 1;
          b_nxt  = b_r >> 1;
          tn_nxt = tn_r >> 1;
          bn_nxt = bn_r >> 1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (diff == '0) begin
          // a_r is the odd part of the GCD; set up the first division
          cnt_nxt = '0;
          rem_nxt = '0;
        end else if (borrow) begin
          // Swap so the larger value sits in a_r for the subtract
          a_nxt = b_r;
          b_nxt = a_r;
        end else begin
          a_nxt = diff[DATA_WIDTH-1:0] >> 1;
        end
      end
      FR_DIV_TOP: begin
        tn_nxt  = q_step;
        rem_nxt = cnt_last ? '0 : rem_step;
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
      end
      FR_DIV_BOT: begin
        bn_nxt  = q_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_last ? '0 : cnt_r + 1'b1;
      end
      FR_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FR_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == FR_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    tn_r     <= tn_nxt;
    bn_r     <= bn_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    tneg_r   <= tneg_nxt;
    bneg_r   <= bneg_nxt;
    status_r <= status_nxt;
    // Load the result register once the previous result has been taken
    if (state_r == FR_DONE && out_free) begin
      out_top_r    <= (status_r == ST_OK) ? tn_r : '0;
      out_bot_r    <= (status_r == ST_OK) ? bn_r : '0;
      out_tneg_r   <= tneg_r;
      out_bneg_r   <= bneg_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_top_magnitude    = out_top_r;
  assign out_bottom_magnitude = out_bot_r;
  assign out_top_negative     = out_tneg_r;
  assign out_bottom_negative  = out_bneg_r;
  assign out_status           = out_status_r;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("item accepted while another is in flight");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FR_GCD) |-> (a_r != '0 && b_r != '0))
    else $error("GCD operand reached zero");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FR_DIV_TOP || state_r == FR_DIV_BOT) |-> (rem_r < a_r))
    else $error("division remainder not below divisor");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_OK) |->
      (out_top_r != '0 && out_bot_r != '0))
    else $error("reduced result has a zero magnitude");

  a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_ZERO_NUM) |->
      (out_top_r == '0 && out_bot_r == '0 && !out_tneg_r))
    else $error("zero numerator result malformed");
`endif

endmodule
`default_nettype wire

FILE: sim/fr_result_checker.sv
// Fraction reducer checker: watches both channels, predicts each reduced fraction and compares.
module fr_result_checker
  import fr_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [W-1:0] in_top_value,
  input  logic [W-1:0] in_bottom_value,
  input  logic         out_valid,
  input  logic         out_ready,
  input  logic [W-1:0] out_top_magnitude,
  input  logic [W-1:0] out_bottom_magnitude,
  input  logic         out_top_negative,
  input  logic         out_bottom_negative,
  input  logic [1:0]   out_status,
  output int           fail_count,
  output int           result_count,
  output int           pending
);

  typedef struct packed {
    logic [W-1:0] top_mag;
    logic [W-1:0] bot_mag;
    logic         top_neg;
    logic         bot_neg;
    fr_status_t   status;
  } reduced_t;

  reduced_t expected_fractions[$];

  assign pending = expected_fractions.size();

  // Lowest terms by Euclid on unsigned magnitudes; signs as given, a zero top made positive.
  function automatic reduced_t reduce_fraction(logic [W-1:0] top, logic [W-1:0] bot);
    reduced_t     r;
    logic [W-1:0] tmag;
    logic [W-1:0] bmag;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] rem;
    r.top_neg = top[W-1];
    r.bot_neg = bot[W-1];
    tmag = top[W-1] ? -top : top;
    bmag = bot[W-1] ? -bot : bot;
    r.top_mag = '0;
    r.bot_mag = '0;
    if (tmag == 0) begin
      r.status  = ST_ZERO_NUM;
      r.top_neg = 1'b0;
    end else if (bmag == 0) begin
      r.status = ST_DIV_ZERO;
    end else begin
      a = tmag;
      b = bmag;
      while (b != 0) begin
        rem = a % b;
        a   = b;
        b   = rem;
      end
      r.top_mag = tmag / a;
      r.bot_mag = bmag / a;
      r.status  = ST_OK;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [W-1:0] want, input logic [W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count   = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    reduced_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_fractions.push_back(reduce_fraction(in_top_value, in_bottom_value));
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_fractions.size() == 0) begin
          $error("result with no item outstanding: top %0d bottom %0d status %0d",
                 out_top_magnitude, out_bottom_magnitude, out_status);
          fail_count++;
        end else begin
          want = expected_fractions.pop_front();
          check_field("top_magnitude", want.top_mag, out_top_magnitude);
          check_field("bottom_magnitude", want.bot_mag, out_bottom_magnitude);
          check_field("top_negative", W'(want.top_neg), W'(out_top_negative));
          check_field("bottom_negative", W'(want.bot_neg), W'(out_bottom_negative));
          check_field("status", W'(want.status), W'(out_status));
        end
      end
    end
  end

endmodule

FILE: sim/tb_top.sv
// Fraction reducer testbench top: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
  import fr_pkg::*;

  localparam int W          = DATA_WIDTH_DEF;
  localparam int RAND_ITEMS = 1300;
  // Room for the worst item plus the longest receiver stall and sender gap, with no
  // handshake at all.
  localparam int IDLE_LIMIT = 2000;
  localparam int INT_MIN    = 32'sh8000_0000;
  localparam int INT_MAX    = 32'sh7fff_ffff;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [W-1:0] in_top_value = '0;
  logic signed [W-1:0] in_bottom_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [W-1:0]        out_top_magnitude;
  logic [W-1:0]        out_bottom_magnitude;
  logic                out_top_negative;
  logic                out_bottom_negative;
  logic [1:0]          out_status;

  int fail_count;
  int result_count;
  int pending;
  int items_sent;
  int drain_count;
  int burst_left;
  int idle_cycles;

  // Directed pairs: zero numerator (also over a zero denominator), zero denominator,
  // most negative and most positive operands, unit and equal magnitudes, coprimes,
  // shared factors and every sign combination.
  int dir_top[$] = '{0, 0, 0, 0, 5, -5, INT_MIN, INT_MAX, INT_MIN, INT_MIN, INT_MAX,
                     INT_MIN, -1, 1, 12, -12, -100, 1, INT_MIN, INT_MAX, 7,
                     32'h4000_0000, -1, 6, -36};
  int dir_bot[$] = '{0, 5, -7, INT_MIN, 0, 0, 0, INT_MAX, INT_MIN, INT_MAX, INT_MIN,
                     -2, -1, 1, -18, 18, -75, INT_MIN, 1, 1, 13,
                     32'h0010_0000, INT_MAX, 4, -48};

  fraction_reducer #(.DATA_WIDTH(W)) DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_top_value        (in_top_value),
    .in_bottom_value     (in_bottom_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_top_magnitude   (out_top_magnitude),
    .out_bottom_magnitude(out_bottom_magnitude),
    .out_top_negative    (out_top_negative),
    .out_bottom_negative (out_bottom_negative),
    .out_status          (out_status)
  );

  fr_result_checker #(.W(W)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_top_value        (in_top_value),
    .in_bottom_value     (in_bottom_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_top_magnitude   (out_top_magnitude),
    .out_bottom_magnitude(out_bottom_magnitude),
    .out_top_negative    (out_top_negative),
    .out_bottom_negative (out_bottom_negative),
    .out_status          (out_status),
    .fail_count          (fail_count),
    .result_count        (result_count),
    .pending             (pending)
  );

  always #6 clk = ~clk;

  // Receiver: alternate ready runs with stall runs of random length; a quarter of the
  // runs carry no stall at all, so some results leave the moment they appear.
  int ready_run = 0;
  int stall_run = 0;

  always @(negedge clk) begin
    if (ready_run > 0) begin
      out_ready <= 1'b1;
      ready_run--;
    end else if (stall_run > 0) begin
      out_ready <= 1'b0;
      stall_run--;
    end else begin
      ready_run = $urandom_range(1, 24);
      stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hang shows as a long run of cycles where neither channel moves an item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles with no item moving", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one item and hold it until it is taken. Between bursts, drop valid for a
  // random gap; inside a burst, the next item follows right behind the last.
  task automatic send_item(input int top, input int bot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_top_value    <= W'(top);
    in_bottom_value <= W'(bot);
    do @(posedge clk); while (!(in_valid && in_ready));
    items_sent++;
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    burst_left = 0;
    drain_count++;
  endtask

  function automatic int apply_sign(int v);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Pick a random numerator and denominator. Four picks in ten build a real common factor so
  // the GCD and both divisions do work; the rest cover raw full-range values, small values
  // shifted by powers of two, tiny values, zeros and the extremes.
  task automatic make_random_pair(output int top, output int bot);
    int g;
    int pick;
    case ($urandom_range(0, 9))
      0, 1: begin
        top = $urandom;
        bot = $urandom;
      end
      2, 3, 4: begin
        g   = $urandom_range(1, 65535);
        top = apply_sign(g * $urandom_range(1, 32767));
        bot = apply_sign(g * $urandom_range(1, 32767));
      end
      5: begin
        top = apply_sign($urandom_range(1, 255) << $urandom_range(0, 23));
        bot = apply_sign($urandom_range(1, 255) << $urandom_range(0, 23));
      end
      6: begin
        top = $urandom_range(0, 40) - 20;
        bot = $urandom_range(0, 40) - 20;
      end
      7: begin
        top = $urandom;
        bot = $urandom;
        if ($urandom_range(0, 1))
          top = 0;
        else
          bot = 0;
      end
      8: begin
        pick = $urandom_range(0, 4);
        top  = (pick == 0) ? INT_MIN : (pick == 1) ? INT_MAX : (pick == 2) ? -1 :
               (pick == 3) ? 1 : INT_MIN + 1;
        bot  = $urandom;
        if ($urandom_range(0, 1)) begin
          g   = top;
          top = bot;
          bot = g;
        end
      end
      default: begin
        top = apply_sign($urandom_range(1, 65535));
        bot = apply_sign(top * $urandom_range(1, 1000));
      end
    endcase
  endtask

  initial begin
    int top;
    int bot;
    items_sent  = 0;
    drain_count = 0;
    burst_left  = 0;
    idle_cycles = 0;

    // Hold reset, then release it on a falling edge.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_top[i])
      send_item(dir_top[i], dir_bot[i]);
    drain();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      make_random_pair(top, bot);
      send_item(top, bot);
      if (n % 300 == 299)
        drain();
    end

    // Wait out the last results, then give the block room to show a stray one.
    drain();
    repeat (20) @(negedge clk);

    $display("Ran %0d items (%0d directed extremes and special cases, the rest random",
             items_sent, dir_top.size());
    $display("full-range, shared-factor and zero operands); %0d results checked, %0d drains",
             result_count, drain_count);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
